### src/segi_pkg.sv
// shared constants and codes for the segment intersection block
`timescale 1ns / 1ps
package segi_pkg;
    localparam int COORD_BITS    = 24;
    localparam int QUEUE_DEPTH   = 8;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [0:0] {
        REG_BOUND_FIRST_SEGMENT = 1'b0
    } t_reg_index;
endpackage

### src/segment_intersection_2d.sv
// throughput: one beat per cycle while o_ready and i_ready stay high;
// the divide is one pipeline stage per quotient bit
// a queue of QUEUE_DEPTH entries lets the front keep taking beats while the result stalls
// reset: synchronous active low, empties all stages, bound_first_segment returns to 1
// top level: config register, front end, queue and back end
`timescale 1ns / 1ps
module segment_intersection_2d #(
    parameter int P_COORD_BITS  = segi_pkg::COORD_BITS,
    parameter int P_QUEUE_DEPTH = segi_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [segi_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [segi_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [segi_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [P_COORD_BITS-1:0]      i_a_start_x,
    input  logic signed [P_COORD_BITS-1:0]      i_a_start_z,
    input  logic signed [P_COORD_BITS-1:0]      i_a_end_x,
    input  logic signed [P_COORD_BITS-1:0]      i_a_end_z,
    input  logic signed [P_COORD_BITS-1:0]      i_b_start_x,
    input  logic signed [P_COORD_BITS-1:0]      i_b_start_z,
    input  logic signed [P_COORD_BITS-1:0]      i_b_end_x,
    input  logic signed [P_COORD_BITS-1:0]      i_b_end_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic signed [P_COORD_BITS-1:0]      o_point_x,
    output logic signed [P_COORD_BITS-1:0]      o_point_z,
    output logic [2*P_COORD_BITS-1:0]           o_dist_squared
);
    import segi_pkg::*;

    localparam int JW = 12 * P_COORD_BITS + 9;
    localparam int LW = $clog2(P_QUEUE_DEPTH + 1);

    logic          r_bound;
    t_reg_index    reg_idx;
    logic          push, pop, nonempty;
    logic [JW-1:0] push_job, head_job;
    logic [LW-1:0] level;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_BOUND_FIRST_SEGMENT: r_bound <= pwdata[0];
                default: r_bound <= r_bound;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BOUND_FIRST_SEGMENT: prdata = {{(APB_DATA_BITS-1){1'b0}}, r_bound};
            default: prdata = '0;
        endcase
    end

    segi_front #(
        .P_COORD_BITS  (P_COORD_BITS),
        .P_QUEUE_DEPTH (P_QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_a_start_x   (i_a_start_x),
        .i_a_start_z   (i_a_start_z),
        .i_a_end_x     (i_a_end_x),
        .i_a_end_z     (i_a_end_z),
        .i_b_start_x   (i_b_start_x),
        .i_b_start_z   (i_b_start_z),
        .i_b_end_x     (i_b_end_x),
        .i_b_end_z     (i_b_end_z),
        .i_queue_level (level),
        .o_push        (push),
        .o_job         (push_job)
    );

    segi_fifo #(
        .P_WIDTH (JW),
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_job),
        .i_pop      (pop),
        .o_data     (head_job),
        .o_nonempty (nonempty),
        .o_level    (level)
    );

    segi_back #(
        .P_COORD_BITS (P_COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bound        (r_bound),
        .i_job_valid    (nonempty),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_point_x      (o_point_x),
        .o_point_z      (o_point_z),
        .o_dist_squared (o_dist_squared)
    );
endmodule

### src/segi_front.sv
// front end: takes beats, forms cross products and flags degenerate or same-side misses
`timescale 1ns / 1ps
module segi_front #(
    parameter int P_COORD_BITS  = 24,
    parameter int P_QUEUE_DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [P_COORD_BITS-1:0]        i_a_start_x,
    input  logic signed [P_COORD_BITS-1:0]        i_a_start_z,
    input  logic signed [P_COORD_BITS-1:0]        i_a_end_x,
    input  logic signed [P_COORD_BITS-1:0]        i_a_end_z,
    input  logic signed [P_COORD_BITS-1:0]        i_b_start_x,
    input  logic signed [P_COORD_BITS-1:0]        i_b_start_z,
    input  logic signed [P_COORD_BITS-1:0]        i_b_end_x,
    input  logic signed [P_COORD_BITS-1:0]        i_b_end_z,
    input  logic [$clog2(P_QUEUE_DEPTH+1)-1:0]    i_queue_level,
    output logic                                  o_push,
    output logic [12*P_COORD_BITS+8:0]            o_job
);
    import segi_pkg::*;

    localparam int W  = P_COORD_BITS;
    localparam int CW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int SW = 2 * W + 3;
    localparam int LW = $clog2(P_QUEUE_DEPTH + 1);

    logic accept;
    logic signed [CW-1:0] dax, daz, dbx, dbz, rb1x, rb1z, rb2x, rb2z;

    logic r_v1, r_v2;
    logic r1_deg, r2_deg;
    logic signed [CW-1:0] r1_dax, r1_daz, r1_dbx, r1_dbz;
    logic signed [CW-1:0] r1_rb1x, r1_rb1z, r1_rb2x, r1_rb2z;
    logic signed [W-1:0]  r1_a1x, r1_a1z, r1_a2x, r1_a2z, r1_b1x, r1_b1z;
    logic signed [W-1:0]  r2_a1x, r2_a1z, r2_a2x, r2_a2z, r2_b1x, r2_b1z;
    logic signed [CW-1:0] r2_dbx, r2_dbz;
    logic signed [PW-1:0] r2_p1, r2_p2, r2_p3, r2_p4, r2_p5, r2_p6;

    logic signed [SW-1:0] s1, s2, den;
    logic same_side, kill;

    // credit check: queue entries plus beats still in the front stages
    assign o_ready = ({1'b0, i_queue_level} + (LW+1)'(r_v1) + (LW+1)'(r_v2))
                     < (LW+1)'(P_QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    assign dax  = i_a_end_x   - i_a_start_x;
    assign daz  = i_a_end_z   - i_a_start_z;
    assign dbx  = i_b_end_x   - i_b_start_x;
    assign dbz  = i_b_end_z   - i_b_start_z;
    assign rb1x = i_b_start_x - i_a_start_x;
    assign rb1z = i_b_start_z - i_a_start_z;
    assign rb2x = i_b_end_x   - i_a_start_x;
    assign rb2z = i_b_end_z   - i_a_start_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_deg  <= ((dax == '0) && (daz == '0)) || ((dbx == '0) && (dbz == '0));
        r1_dax  <= dax;
        r1_daz  <= daz;
        r1_dbx  <= dbx;
        r1_dbz  <= dbz;
        r1_rb1x <= rb1x;
        r1_rb1z <= rb1z;
        r1_rb2x <= rb2x;
        r1_rb2z <= rb2z;
        r1_a1x  <= i_a_start_x;
        r1_a1z  <= i_a_start_z;
        r1_a2x  <= i_a_end_x;
        r1_a2z  <= i_a_end_z;
        r1_b1x  <= i_b_start_x;
        r1_b1z  <= i_b_start_z;

        r2_deg  <= r1_deg;
        r2_p1   <= r1_dax * r1_rb1z;
        r2_p2   <= r1_daz * r1_rb1x;
        r2_p3   <= r1_dax * r1_rb2z;
        r2_p4   <= r1_daz * r1_rb2x;
        r2_p5   <= r1_dax * r1_dbz;
        r2_p6   <= r1_daz * r1_dbx;
        r2_a1x  <= r1_a1x;
        r2_a1z  <= r1_a1z;
        r2_a2x  <= r1_a2x;
        r2_a2z  <= r1_a2z;
        r2_b1x  <= r1_b1x;
        r2_b1z  <= r1_b1z;
        r2_dbx  <= r1_dbx;
        r2_dbz  <= r1_dbz;
    end

    assign s1  = r2_p1 - r2_p2;
    assign s2  = r2_p3 - r2_p4;
    assign den = r2_p6 - r2_p5;

    assign same_side = (s1[SW-1] == s2[SW-1]) && ((s1 == '0) == (s2 == '0));
    assign kill      = r2_deg || same_side;

    assign o_push = r_v2;
    assign o_job  = {kill, s1, den, r2_a1x, r2_a1z, r2_a2x, r2_a2z,
                     r2_b1x, r2_b1z, r2_dbx, r2_dbz};
endmodule

### src/segi_fifo.sv
// short queue between the front end and the back end
`timescale 1ns / 1ps
module segi_fifo #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [P_WIDTH-1:0]               i_data,
    input  logic                             i_pop,
    output logic [P_WIDTH-1:0]               o_data,
    output logic                             o_nonempty,
    output logic [$clog2(P_DEPTH+1)-1:0]     o_level
);
    import segi_pkg::*;

    localparam int AW = $clog2(P_DEPTH);
    localparam int LW = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [AW-1:0]      r_wr_ptr, r_rd_ptr;
    logic [LW-1:0]      r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_level != '0);
    assign o_level    = r_level;
endmodule

### src/segi_back.sv
// back end: pipelined interpolation divide, bound test and distance
`timescale 1ns / 1ps
module segi_back #(
    parameter int P_COORD_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_bound,
    input  logic                            i_job_valid,
    input  logic [12*P_COORD_BITS+8:0]      i_job,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_hit,
    output logic signed [P_COORD_BITS-1:0]  o_point_x,
    output logic signed [P_COORD_BITS-1:0]  o_point_z,
    output logic [2*P_COORD_BITS-1:0]       o_dist_squared
);
    import segi_pkg::*;

    localparam int W   = P_COORD_BITS;
    localparam int CW  = W + 1;
    localparam int QW  = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int SW  = 2 * W + 3;
    localparam int LO  = W + 2;
    localparam int HI  = SW - LO;
    localparam int PRW = SW + CW;

    typedef struct packed {
        logic                kill;
        logic                negx;
        logic                negz;
        logic signed [W-1:0] a1x;
        logic signed [W-1:0] a1z;
        logic signed [W-1:0] a2x;
        logic signed [W-1:0] a2z;
        logic signed [W-1:0] b1x;
        logic signed [W-1:0] b1z;
    } t_side;

    logic          j_kill;
    logic [SW-1:0] j_s1, j_den;
    logic [W-1:0]  j_a1x, j_a1z, j_a2x, j_a2z, j_b1x, j_b1z;
    logic [CW-1:0] j_dbx, j_dbz;
    logic          en;

    logic r_v0, r_v1, r_v3, r_v4, r_vo;
    logic r_dv [QW+1];

    t_side         r0_side, r1_side, r3_side, r4_side;
    logic [SW-1:0] r0_ms1, r0_mden, r1_mden;
    logic [CW-1:0] r0_mdbx, r0_mdbz;
    logic [LO+CW-1:0] r1_lox, r1_loz;
    logic [HI+CW-1:0] r1_hix, r1_hiz;

    t_side         r_side [QW+1];
    logic [SW-1:0] r_den  [QW+1];
    logic [SW-1:0] r_remx [QW+1];
    logic [SW-1:0] r_remz [QW+1];
    logic [QW-1:0] r_lowx [QW+1];
    logic [QW-1:0] r_lowz [QW+1];
    logic [QW-1:0] r_qx   [QW+1];
    logic [QW-1:0] r_qz   [QW+1];

    logic [PRW-1:0] prodx, prodz;

    logic signed [W+1:0] sum_x, sum_z;
    logic signed [W-1:0] r3_px, r3_pz, r4_px, r4_pz;
    logic [QW-1:0]       r3_qx, r3_qz;

    logic signed [CW-1:0] dx1, dx2, dz1, dz2;
    logic signed [PW-1:0] r4_dotx, r4_dotz;
    logic [PW-1:0]        r4_sqx, r4_sqz;

    logic signed [SW-1:0] dot;
    logic [PW:0]          dist_sum;
    logic                 hit;

    logic                 r_hit;
    logic signed [W-1:0]  r_px, r_pz;
    logic [2*W-1:0]       r_dist;

    assign {j_kill, j_s1, j_den, j_a1x, j_a1z, j_a2x, j_a2z,
            j_b1x, j_b1z, j_dbx, j_dbz} = i_job;

    // the whole back pipe moves together and holds while the result waits
    assign en    = !r_vo || i_ready;
    assign o_pop = en && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_dv[0]  <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_vo     <= 1'b0;
        end else if (en) begin
            r_v0     <= i_job_valid;
            r_v1     <= r_v0;
            r_dv[0]  <= r_v1;
            r_v3     <= r_dv[QW];
            r_v4     <= r_v3;
            r_vo     <= r_v4;
        end
    end

    // magnitudes and result signs
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_side.kill <= j_kill;
            r0_side.negx <= j_s1[SW-1] ^ j_den[SW-1] ^ j_dbx[CW-1];
            r0_side.negz <= j_s1[SW-1] ^ j_den[SW-1] ^ j_dbz[CW-1];
            r0_side.a1x  <= j_a1x;
            r0_side.a1z  <= j_a1z;
            r0_side.a2x  <= j_a2x;
            r0_side.a2z  <= j_a2z;
            r0_side.b1x  <= j_b1x;
            r0_side.b1z  <= j_b1z;
            r0_ms1  <= j_s1[SW-1]  ? (~j_s1 + 1'b1)  : j_s1;
            r0_mden <= j_den[SW-1] ? (~j_den + 1'b1) : j_den;
            r0_mdbx <= j_dbx[CW-1] ? (~j_dbx + 1'b1) : j_dbx;
            r0_mdbz <= j_dbz[CW-1] ? (~j_dbz + 1'b1) : j_dbz;
        end
    end

    // partial products of the numerator
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side <= r0_side;
            r1_mden <= r0_mden;
            r1_lox  <= r0_ms1[LO-1:0]  * r0_mdbx;
            r1_hix  <= r0_ms1[SW-1:LO] * r0_mdbx;
            r1_loz  <= r0_ms1[LO-1:0]  * r0_mdbz;
            r1_hiz  <= r0_ms1[SW-1:LO] * r0_mdbz;
        end
    end

    assign prodx = (PRW'(r1_hix) << LO) + PRW'(r1_lox);
    assign prodz = (PRW'(r1_hiz) << LO) + PRW'(r1_loz);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r1_side;
            r_den[0]  <= r1_mden;
            r_remx[0] <= prodx[PRW-1:QW];
            r_remz[0] <= prodz[PRW-1:QW];
            r_lowx[0] <= prodx[QW-1:0];
            r_lowz[0] <= prodz[QW-1:0];
            r_qx[0]   <= '0;
            r_qz[0]   <= '0;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [SW:0] tx, tz, dfx, dfz;
        logic        gex, gez;

        assign tx  = {r_remx[k], r_lowx[k][QW-1]};
        assign tz  = {r_remz[k], r_lowz[k][QW-1]};
        assign gex = tx >= {1'b0, r_den[k]};
        assign gez = tz >= {1'b0, r_den[k]};
        assign dfx = tx - {1'b0, r_den[k]};
        assign dfz = tz - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[k+1] <= r_side[k];
                r_den[k+1]  <= r_den[k];
                r_remx[k+1] <= gex ? dfx[SW-1:0] : tx[SW-1:0];
                r_remz[k+1] <= gez ? dfz[SW-1:0] : tz[SW-1:0];
                r_lowx[k+1] <= r_lowx[k] << 1;
                r_lowz[k+1] <= r_lowz[k] << 1;
                r_qx[k+1]   <= {r_qx[k][QW-2:0], gex};
                r_qz[k+1]   <= {r_qz[k][QW-2:0], gez};
            end
        end
    end

    assign sum_x = r_side[QW].negx
                 ? ((W+2)'(r_side[QW].b1x) - $signed({1'b0, r_qx[QW]}))
                 : ((W+2)'(r_side[QW].b1x) + $signed({1'b0, r_qx[QW]}));
    assign sum_z = r_side[QW].negz
                 ? ((W+2)'(r_side[QW].b1z) - $signed({1'b0, r_qz[QW]}))
                 : ((W+2)'(r_side[QW].b1z) + $signed({1'b0, r_qz[QW]}));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side <= r_side[QW];
            r3_px   <= sum_x[W-1:0];
            r3_pz   <= sum_z[W-1:0];
            r3_qx   <= r_qx[QW];
            r3_qz   <= r_qz[QW];
        end
    end

    assign dx1 = r3_px - r3_side.a1x;
    assign dx2 = r3_px - r3_side.a2x;
    assign dz1 = r3_pz - r3_side.a1z;
    assign dz2 = r3_pz - r3_side.a2z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side <= r3_side;
            r4_px   <= r3_px;
            r4_pz   <= r3_pz;
            r4_dotx <= dx1 * dx2;
            r4_dotz <= dz1 * dz2;
            r4_sqx  <= r3_qx * r3_qx;
            r4_sqz  <= r3_qz * r3_qz;
        end
    end

    assign dot      = r4_dotx + r4_dotz;
    assign dist_sum = {1'b0, r4_sqx} + {1'b0, r4_sqz};
    assign hit      = !r4_side.kill && !(i_bound && !dot[SW-1] && (dot != '0));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit  <= hit;
            r_px   <= hit ? r4_px : '0;
            r_pz   <= hit ? r4_pz : '0;
            r_dist <= !hit ? '0
                    : ((dist_sum[PW:2*W] != '0) ? '1 : dist_sum[2*W-1:0]);
        end
    end

    assign o_valid        = r_vo;
    assign o_hit          = r_hit;
    assign o_point_x      = r_px;
    assign o_point_z      = r_pz;
    assign o_dist_squared = r_dist;
endmodule

### src/segi_checker.sv
// port-level checks for the segment intersection block, bound to the top level
`timescale 1ns / 1ps
module segi_checker #(
    parameter int P_COORD_BITS = segi_pkg::COORD_BITS
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                pready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic                                o_hit,
    input logic signed [P_COORD_BITS-1:0]      o_point_x,
    input logic signed [P_COORD_BITS-1:0]      o_point_z,
    input logic [2*P_COORD_BITS-1:0]           o_dist_squared
);
    import segi_pkg::*;

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_point_x == '0 && o_point_z == '0 && o_dist_squared == '0)
        else $error("miss beat with nonzero payload");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit) && $stable(o_point_x)
            && $stable(o_point_z) && $stable(o_dist_squared))
        else $error("stalled result changed");

    // config port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");
endmodule

bind segment_intersection_2d segi_checker #(.P_COORD_BITS(P_COORD_BITS)) u_segi_checker (.*);

### verif/testbench.sv
// self-checking testbench for the 2d segment intersection block
`timescale 1ns / 1ps
module testbench;
    import segi_pkg::*;

    localparam int CB = COORD_BITS;
    localparam logic [2*CB-1:0] DIST_MAX = '1;
    localparam int DRAIN_CYCLES = CB + 30;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [CB-1:0] t_coord;

    typedef struct {
        t_coord a1x, a1z, a2x, a2z, b1x, b1z, b2x, b2z;
    } t_query;

    typedef struct {
        logic            hit;
        t_coord          px;
        t_coord          pz;
        logic [2*CB-1:0] sq_dist;
    } t_crossing;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    t_coord                   i_a_start_x = '0, i_a_start_z = '0, i_a_end_x = '0;
    t_coord                   i_a_end_z = '0, i_b_start_x = '0, i_b_start_z = '0;
    t_coord                   i_b_end_x = '0, i_b_end_z = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic                     o_hit;
    t_coord                   o_point_x, o_point_z;
    logic [2*CB-1:0]          o_dist_squared;

    t_crossing expected_crossings[$];
    bit        bound_mode = 1'b1;
    bit        sender_gaps = 1'b1;
    bit        receiver_stalls = 1'b1;
    bit        long_hold_req = 1'b0;
    int        errors = 0;

    segment_intersection_2d u_top (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #(20 * 2000000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int wide_sign(t_wide v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    function automatic t_crossing predict_crossing(t_query q, bit bounded);
        t_wide a1x, a1z, a2x, a2z, b1x, b1z, b2x, b2z;
        t_wide dax, daz, dbx, dbz, s1, s2, den, px, pz, dot, ex, ez, dist_sq;
        t_crossing r;
        a1x = q.a1x; a1z = q.a1z; a2x = q.a2x; a2z = q.a2z;
        b1x = q.b1x; b1z = q.b1z; b2x = q.b2x; b2z = q.b2z;
        r = '{1'b0, '0, '0, '0};
        dax = a2x - a1x; daz = a2z - a1z;
        dbx = b2x - b1x; dbz = b2z - b1z;
        if (dax == 0 && daz == 0) return r;
        if (dbx == 0 && dbz == 0) return r;
        s1 = dax * (b1z - a1z) - daz * (b1x - a1x);
        s2 = dax * (b2z - a1z) - daz * (b2x - a1x);
        if (wide_sign(s1) == wide_sign(s2)) return r;
        den = s1 - s2;
        px = b1x + (dbx * s1) / den;
        pz = b1z + (dbz * s1) / den;
        dot = (px - a1x) * (px - a2x) + (pz - a1z) * (pz - a2z);
        if (bounded && dot > 0) return r;
        ex = px - b1x;
        ez = pz - b1z;
        dist_sq = ex * ex + ez * ez;
        r.hit = 1'b1;
        r.px = px[CB-1:0];
        r.pz = pz[CB-1:0];
        r.sq_dist = (dist_sq > t_wide'(DIST_MAX)) ? DIST_MAX : dist_sq[2*CB-1:0];
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_crossing exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_crossings.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat hit=%0b", o_hit);
            end else begin
                exp_r = expected_crossings.pop_front();
                if (o_hit !== exp_r.hit || o_point_x !== exp_r.px ||
                    o_point_z !== exp_r.pz || o_dist_squared !== exp_r.sq_dist) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp hit=%0b x=%0d z=%0d d=%0d",
                                  " got hit=%0b x=%0d z=%0d d=%0d"},
                                 exp_r.hit, exp_r.px, exp_r.pz, exp_r.sq_dist,
                                 o_hit, o_point_x, o_point_z, o_dist_squared);
                end
            end
        end
    end

    // result side flow control
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            n = receiver_stalls ? $urandom_range(0, 7) : 0;
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    task automatic send_query(t_query q);
        int n;
        n = sender_gaps ? $urandom_range(0, 7) : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_a_start_x <= q.a1x; i_a_start_z <= q.a1z;
        i_a_end_x <= q.a2x;   i_a_end_z <= q.a2z;
        i_b_start_x <= q.b1x; i_b_start_z <= q.b1z;
        i_b_end_x <= q.b2x;   i_b_end_z <= q.b2z;
        do @(posedge i_clk); while (!o_ready);
        expected_crossings.push_back(predict_crossing(q, bound_mode));
    endtask

    task automatic wait_drained();
        if (i_valid) i_valid <= 1'b0;
        while (expected_crossings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bound_mode(logic [APB_DATA_BITS-1:0] value);
        wait_drained();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'(REG_BOUND_FIRST_SEGMENT) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        bound_mode = value[0];
    endtask

    function automatic t_coord rand_coord(int span);
        if (span >= 23) return t_coord'($urandom);
        return t_coord'($signed($urandom_range(0, (1 << (span + 1)) - 1)) - (1 << span));
    endfunction

    function automatic t_query random_query();
        t_query q;
        int span, cx, cz, k;
        k = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 23 : $urandom_range(2, 14);
        if (k < 5) begin
            // both segments pass near a common center
            cx = int'(rand_coord(21)); cz = int'(rand_coord(21));
            q.a1x = t_coord'(cx + rand_coord(span));
            q.a1z = t_coord'(cz + rand_coord(span));
            q.a2x = t_coord'(2 * cx - q.a1x + rand_coord(2));
            q.a2z = t_coord'(2 * cz - q.a1z + rand_coord(2));
            q.b1x = t_coord'(cx + rand_coord(span));
            q.b1z = t_coord'(cz + rand_coord(span));
            q.b2x = t_coord'(2 * cx - q.b1x + rand_coord(2));
            q.b2z = t_coord'(2 * cz - q.b1z + rand_coord(2));
        end else begin
            q.a1x = rand_coord(span); q.a1z = rand_coord(span);
            q.a2x = rand_coord(span); q.a2z = rand_coord(span);
            q.b1x = rand_coord(span); q.b1z = rand_coord(span);
            q.b2x = rand_coord(span); q.b2z = rand_coord(span);
            if (k == 9) begin
                q.b2x = q.b1x; q.b2z = q.b1z;
            end
        end
        return q;
    endfunction

    task automatic test_directed_cases();
        t_coord mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        // plain cross, degenerate a, degenerate b
        send_query('{-256, 0, 256, 0, 0, -256, 0, 256});
        send_query('{100, 100, 100, 100, 0, -256, 0, 256});
        send_query('{-256, 0, 256, 0, 50, 50, 50, 50});
        // collinear, parallel, same side
        send_query('{0, 0, 512, 0, -100, 0, 900, 0});
        send_query('{0, 0, 512, 0, 0, 10, 512, 10});
        send_query('{0, 0, 512, 0, 0, 10, 512, 300});
        // endpoint on line, both ends
        send_query('{0, 0, 512, 0, 100, 0, 100, 300});
        send_query('{0, 0, 512, 0, 100, -300, 100, 0});
        // crossing outside a
        send_query('{0, 0, 512, 0, 2000, -5, 2100, 7});
        // full range extremes and distance saturation
        send_query('{mn, mn, mx, mx, mn, mx, mx, mn});
        send_query('{8388000, mn, 8388000, mx, mn, mn, mx, mx});
        send_query('{mx, mn, mx, mx, mn, mn, mx, mx});
        send_query('{mn, 0, mx, 0, 3, mn, -3, mx});
        send_query('{-1, -1, 1, 1, -1, 1, 1, -1});
        send_query('{mn, mx, mx, mn, -7, -7, 9, 9});
    endtask

    task automatic test_directed_both_modes();
        write_bound_mode(32'd0);
        test_directed_cases();
        write_bound_mode(32'd1);
        test_directed_cases();
    endtask

    task automatic test_random_queries(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                sender_gaps = $urandom_range(0, 2) != 0;
                receiver_stalls = $urandom_range(0, 2) != 0;
            end
            send_query(random_query());
        end
    endtask

    task automatic test_random_mode_switching();
        write_bound_mode(32'hFFFF_FFFE);
        test_random_queries(150);
        write_bound_mode(32'hFFFF_FFFF);
        test_random_queries(150);
        write_bound_mode(32'h0000_0000);
        test_random_queries(100);
        write_bound_mode(32'h0000_0001);
    endtask

    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 80; i++) send_query(random_query());
        wait_drained();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        test_random_queries(20);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_directed_both_modes();
        test_output_backpressure();
        test_random_mode_switching();
        wait_drained();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
